// ===== hdl/imu_sensor_frame_parser_assert.svh =====
`ifndef IMU_SENSOR_FRAME_PARSER_ASSERT_SVH
`define IMU_SENSOR_FRAME_PARSER_ASSERT_SVH

// clocked assertion, off while reset is high
`define IMU_SFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, also checked across reset
`define IMU_SFP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/imu_sfp_pkg.sv =====
package imu_sfp_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] TYPE_QUAT  = 8'h59;

   localparam logic [3:0] POS_HUNT   = 4'd0;
   localparam logic [3:0] POS_TYPE   = 4'd1;
   localparam logic [3:0] POS_FIRST  = 4'd2;
   localparam logic [3:0] FRAME_LAST = 4'd10;

   localparam int PAYLOAD_DEPTH = 8;

   localparam logic [1:0] KIND_ACC   = 2'd0;
   localparam logic [1:0] KIND_GYRO  = 2'd1;
   localparam logic [1:0] KIND_ANGLE = 2'd2;
   localparam logic [1:0] KIND_QUAT  = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_last;
   } req_type;

   typedef struct packed {
      logic [1:0]         frame_kind;
      logic signed [15:0] word_a;
      logic signed [15:0] word_b;
      logic signed [15:0] word_c;
      logic signed [15:0] word_d;
   } rsp_type;

   typedef struct packed {
      logic    produce;
      rsp_type rsp;
   } frame_result_type;

endpackage

// ===== hdl/imu_sfp_byte_reg.sv =====
module imu_sfp_byte_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  imu_sfp_pkg::req_type req_data,
   input  logic                take,
   output logic                byte_valid,
   output imu_sfp_pkg::req_type byte_data
);
   import imu_sfp_pkg::*;

   logic    vld_ff, vld_in;
   req_type data_ff, data_in;

   assign req_ready = !vld_ff || take;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (req_valid && req_ready) begin
         vld_in  = 1'b1;
         data_in = req_data;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = vld_ff;
   assign byte_data  = data_ff;
endmodule

// ===== hdl/imu_sfp_frame_fsm.sv =====
module imu_sfp_frame_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  imu_sfp_pkg::req_type         byte_data,
   output imu_sfp_pkg::frame_result_type result
);
   import imu_sfp_pkg::*;

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] payload_ff [PAYLOAD_DEPTH];
   logic [3:0] pos_m2;
   logic [2:0] wr_idx;
   logic       wr_en;
   logic       kind_ok;
   logic [1:0] kind;
   logic [7:0] b;

   assign b      = byte_data.rx_byte;
   assign pos_m2 = pos_ff - POS_FIRST;
   assign wr_idx = pos_m2[2:0];

   always_comb begin
      kind_ok = 1'b1;
      kind    = KIND_ACC;
      unique case (type_ff)
         TYPE_ACC:   kind = KIND_ACC;
         TYPE_GYRO:  kind = KIND_GYRO;
         TYPE_ANGLE: kind = KIND_ANGLE;
         TYPE_QUAT:  kind = KIND_QUAT;
         default:    kind_ok = 1'b0;
      endcase
   end

   always_comb begin
      pos_in                = pos_ff;
      sum_in                = sum_ff;
      type_in               = type_ff;
      wr_en                 = 1'b0;
      result.produce        = 1'b0;
      result.rsp.frame_kind = kind;
      result.rsp.word_a     = {payload_ff[1], payload_ff[0]};
      result.rsp.word_b     = {payload_ff[3], payload_ff[2]};
      result.rsp.word_c     = {payload_ff[5], payload_ff[4]};
      result.rsp.word_d     = (kind == KIND_QUAT) ? {payload_ff[7], payload_ff[6]} : 16'sd0;
      if (go) begin
         priority if (pos_ff == POS_HUNT || pos_ff > FRAME_LAST) begin
            if (b == HDR_BYTE) begin
               sum_in = b;
               pos_in = POS_TYPE;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_TYPE) begin
            type_in = b;
            sum_in  = sum_ff + b;
            pos_in  = POS_FIRST;
         end else if (pos_ff < FRAME_LAST) begin
            wr_en  = 1'b1;
            sum_in = sum_ff + b;
            pos_in = pos_ff + 4'd1;
         end else begin
            result.produce = kind_ok && (sum_ff == b);
            pos_in         = POS_HUNT;
         end
         if (byte_data.buffer_last) begin
            pos_in = POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HUNT;
         sum_ff  <= 8'd0;
         type_ff <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         type_ff <= type_in;
      end
      if (wr_en) begin
         payload_ff[wr_idx] <= b;
      end
   end
endmodule

// ===== hdl/imu_sfp_rsp_reg.sv =====
module imu_sfp_rsp_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  imu_sfp_pkg::frame_result_type result,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output imu_sfp_pkg::rsp_type         rsp_data
);
   import imu_sfp_pkg::*;

   logic    vld_ff, vld_in;
   rsp_type data_ff, data_in;
   logic    load;

   assign out_free = !vld_ff || rsp_ready;
   assign load     = go && result.produce;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (load) begin
         vld_in  = 1'b1;
         data_in = result.rsp;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;
endmodule

// ===== hdl/imu_sensor_frame_parser.sv =====
// Checksum byte path: byte register, frame FSM, result register (rsp_valid).
// Throughput: one byte per cycle; the result register stalls the byte stage
// only while a result waits with rsp_ready low.
// Reset: synchronous, active high; clears valids, byte position, sum and type.
// Payload byte registers are not reset.
module imu_sensor_frame_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  imu_sfp_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output imu_sfp_pkg::rsp_type rsp_data
);
   import imu_sfp_pkg::*;

   logic             byte_valid;
   req_type          byte_data;
   logic             out_free;
   logic             go;
   frame_result_type result;

   assign go = byte_valid && out_free;

   imu_sfp_byte_reg u_byte_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (go),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   imu_sfp_frame_fsm u_frame_fsm (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .byte_data (byte_data),
      .result    (result)
   );

   imu_sfp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== hdl/imu_sfp_checker.sv =====
`include "imu_sensor_frame_parser_assert.svh"

module imu_sfp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input imu_sfp_pkg::req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input imu_sfp_pkg::rsp_type rsp_data
);
   import imu_sfp_pkg::*;

   `IMU_SFP_ASSERT_RST(a_idle_after_reset, reset |=> !rsp_valid, "rsp_valid after reset")
   `IMU_SFP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp dropped or changed while stalled")
   `IMU_SFP_ASSERT(a_new_rsp_has_source, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "result without a byte transaction two cycles earlier")
   `IMU_SFP_ASSERT(a_word_d_zero, rsp_valid && rsp_data.frame_kind != KIND_QUAT |-> rsp_data.word_d == 16'sd0, "word_d nonzero on non-quaternion frame")
endmodule

bind imu_sensor_frame_parser imu_sfp_checker u_checker (.*);

// ===== sim/imu_sfp_checker.sv =====
`timescale 1ns / 100ps

module imu_sfp_tb_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  imu_sfp_pkg::req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  imu_sfp_pkg::rsp_type rsp_data,
   output int                   mismatches,
   output int                   frames_pending
);
   import imu_sfp_pkg::*;

   logic [3:0] frame_pos;
   logic [7:0] frame_sum;
   logic [7:0] frame_type;
   logic [7:0] frame_payload [PAYLOAD_DEPTH];
   rsp_type    expected_frames [$];

   function automatic logic [15:0] payload_word(int k);
      return {frame_payload[2 * k + 1], frame_payload[2 * k]};
   endfunction

   // advance the frame tracker by one byte transaction
   task automatic parse_byte(req_type item);
      rsp_type    frame;
      logic       known;
      logic [3:0] slot;
      frame = '0;
      known = 1'b1;
      slot  = frame_pos - POS_FIRST;
      if (frame_pos == POS_HUNT || frame_pos > FRAME_LAST) begin
         if (item.rx_byte == HDR_BYTE) begin
            frame_sum = item.rx_byte;
            frame_pos = POS_TYPE;
         end else begin
            frame_pos = POS_HUNT;
         end
      end else if (frame_pos == POS_TYPE) begin
         frame_type = item.rx_byte;
         frame_sum  = frame_sum + item.rx_byte;
         frame_pos  = POS_FIRST;
      end else if (frame_pos < FRAME_LAST) begin
         frame_payload[slot[2:0]] = item.rx_byte;
         frame_sum = frame_sum + item.rx_byte;
         frame_pos = frame_pos + 4'd1;
      end else begin
         case (frame_type)
            TYPE_ACC:   frame.frame_kind = KIND_ACC;
            TYPE_GYRO:  frame.frame_kind = KIND_GYRO;
            TYPE_ANGLE: frame.frame_kind = KIND_ANGLE;
            TYPE_QUAT:  frame.frame_kind = KIND_QUAT;
            default:    known = 1'b0;
         endcase
         if (known && frame_sum == item.rx_byte) begin
            frame.word_a = payload_word(0);
            frame.word_b = payload_word(1);
            frame.word_c = payload_word(2);
            frame.word_d = (frame.frame_kind == KIND_QUAT) ? payload_word(3) : 16'sd0;
            expected_frames.push_back(frame);
         end
         frame_pos = POS_HUNT;
      end
      if (item.buffer_last) begin
         frame_pos = POS_HUNT;
      end
   endtask

   task automatic flag_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t checker %s: expected kind %0d a %0d b %0d c %0d d %0d",
                  $realtime, what, want.frame_kind, want.word_a, want.word_b,
                  want.word_c, want.word_d);
         $display("%0t checker %s: actual   kind %0d a %0d b %0d c %0d d %0d",
                  $realtime, what, got.frame_kind, got.word_a, got.word_b,
                  got.word_c, got.word_d);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         frame_pos  = POS_HUNT;
         frame_sum  = '0;
         frame_type = '0;
         expected_frames.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               flag_mismatch("unexpected result", '0, rsp_data);
            end else begin
               want = expected_frames.pop_front();
               if (want.frame_kind !== rsp_data.frame_kind || want.word_a !== rsp_data.word_a ||
                   want.word_b !== rsp_data.word_b || want.word_c !== rsp_data.word_c ||
                   want.word_d !== rsp_data.word_d) begin
                  flag_mismatch("field mismatch", want, rsp_data);
               end
            end
         end
      end
      frames_pending <= expected_frames.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import imu_sfp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int BYTE_TARGET  = 1650;
   localparam int HOLD_START   = 800;
   localparam int HOLD_CYCLES  = 250;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      frames_pending;
   int      bytes_sent;
   int      burst_left;
   int      cycles;

   imu_sensor_frame_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   imu_sfp_tb_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatches     (mismatches),
      .frames_pending (frames_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // one byte transaction, then possibly a gap between bursts
   task automatic send_byte(logic [7:0] value, logic last);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: value, buffer_last: last};
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 3))
         0:       return TYPE_ACC;
         1:       return TYPE_GYRO;
         2:       return TYPE_ANGLE;
         default: return TYPE_QUAT;
      endcase
   endfunction

   task automatic send_frame(logic [7:0] type_code, logic [7:0] payload [8],
                             logic [7:0] sum_skew, logic last_on_sum);
      logic [7:0] sum;
      sum = HDR_BYTE + type_code;
      send_byte(HDR_BYTE, 1'b0);
      send_byte(type_code, 1'b0);
      for (int i = 0; i < 8; i++) begin
         send_byte(payload[i], 1'b0);
         sum = sum + payload[i];
      end
      send_byte(sum + sum_skew, last_on_sum);
   endtask

   initial begin
      logic [7:0] payload [8];
      logic [7:0] type_code;
      int         count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extreme words in a quaternion frame
      payload = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00};
      send_frame(TYPE_QUAT, payload, 8'h00, 1'b0);
      // header alone at the end of a buffer
      send_byte(HDR_BYTE, 1'b1);
      // frame cut short by the end of a buffer
      send_byte(HDR_BYTE, 1'b0);
      send_byte(TYPE_GYRO, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b1);
      // buffer ends on the checksum byte
      payload = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0};
      send_frame(TYPE_ANGLE, payload, 8'h00, 1'b1);

      while (bytes_sent < BYTE_TARGET) begin
         for (int i = 0; i < 8; i++) begin
            payload[i] = pick_byte();
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               send_frame(pick_type(), payload, 8'h00, $urandom_range(0, 3) == 0);
            end
            6: begin
               send_frame(pick_type(), payload, 8'($urandom_range(1, 255)),
                          $urandom_range(0, 3) == 0);
            end
            7: begin
               do type_code = 8'($urandom_range(0, 255));
               while (type_code == TYPE_ACC || type_code == TYPE_GYRO ||
                      type_code == TYPE_ANGLE || type_code == TYPE_QUAT);
               send_frame(type_code, payload, 8'h00, 1'($urandom_range(0, 1)));
            end
            8: begin
               count = $urandom_range(0, 9);
               send_byte(HDR_BYTE, count == 0);
               for (int i = 0; i < count; i++) begin
                  send_byte(i == 0 ? pick_type() : pick_byte(), i == count - 1);
               end
            end
            default: begin
               count = $urandom_range(1, 12);
               for (int i = 0; i < count; i++) begin
                  send_byte(($urandom_range(0, 5) == 0) ? HDR_BYTE : pick_byte(),
                            $urandom_range(0, 15) == 0);
               end
            end
         endcase
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (frames_pending != 0);
      repeat (12) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && frames_pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // receiver stall pattern with one long hold-off to back up the parser
   initial begin
      int  rx_cycles;
      int  stretch;
      int  mode;
      logic held;
      held = 1'b0;
      rx_cycles = 0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && rx_cycles >= HOLD_START) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_cycles += HOLD_CYCLES;
         end
         stretch = $urandom_range(1, 40);
         mode    = $urandom_range(0, 3);
         for (int i = 0; i < stretch; i++) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= 1'b0;
            endcase
            @(posedge clock);
            rx_cycles++;
         end
      end
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/imu_sfp_pkg.sv
hdl/imu_sfp_byte_reg.sv
hdl/imu_sfp_frame_fsm.sv
hdl/imu_sfp_rsp_reg.sv
hdl/imu_sensor_frame_parser.sv
hdl/imu_sfp_checker.sv
sim/imu_sfp_checker.sv
sim/tb.sv
